// ===== hw/rtl/wwa_pkg.sv =====
// Shared types, constants and the vane lookup for the wind window average core.
// Used by wind_window_average_core; depends on nothing else.
package wwa_pkg;

   // Field widths
   localparam int SPEED_W    = 8;
   localparam int VANE_W     = 10;
   localparam int DIR_W      = 10;   // stored heading, two's complement
   localparam int RUN_W      = 11;   // unwrapped running angle, signed
   localparam int SPD_MEAN_W = 16;
   localparam int DIR_MEAN_W = 9;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam int WINDOW_DEF = 300;

   // Angle constants
   localparam logic signed [RUN_W-1:0] DEG_FULL  = 11'sd360;
   localparam logic signed [RUN_W:0]   DEG_HALF  = 12'sd180;
   localparam logic signed [DIR_W-1:0] DIR_FAULT = -10'sd1;

   // Request kinds carried on tuser
   typedef enum logic {
      KIND_SAMPLE  = 1'b0,
      KIND_COMPUTE = 1'b1
   } kind_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_SPD_GO,
      ST_SPD_WAIT,
      ST_ANG_GO,
      ST_ANG_WAIT,
      ST_FINISH
   } state_type;

   // Vane thresholds and the heading for a reading below each one
   localparam int NUM_VANE = 16;
   localparam logic [VANE_W-1:0] VANE_LIMIT [NUM_VANE] = '{
      10'd380, 10'd393, 10'd414, 10'd456, 10'd508, 10'd551, 10'd615, 10'd680,
      10'd746, 10'd801, 10'd833, 10'd878, 10'd913, 10'd940, 10'd967, 10'd990
   };
   localparam logic signed [DIR_W-1:0] VANE_HEADING [NUM_VANE] = '{
      10'sd113, 10'sd68,  10'sd90,  10'sd158, 10'sd135, 10'sd203, 10'sd180, 10'sd23,
      10'sd45,  10'sd248, 10'sd225, 10'sd338, 10'sd0,   10'sd293, 10'sd315, 10'sd270
   };

   // First threshold above the reading wins; at or above the top one is a fault
   function automatic logic signed [DIR_W-1:0] heading_of(input logic [VANE_W-1:0] adc);
      logic signed [DIR_W-1:0] h;
      h = DIR_FAULT;
      for (int k = NUM_VANE - 1; k >= 0; k--) begin
         if (adc < VANE_LIMIT[k]) h = VANE_HEADING[k];
      end
      return h;
   endfunction

endpackage

// ===== hw/rtl/wwa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wwa_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 300
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/wwa_div.sv =====
// Divider by a fixed divisor: the registered dividend is multiplied by a
// rounded-up reciprocal and shifted into a registered quotient with a done pulse.
// Depends on nothing; shared by the speed and angle averages.
module wwa_div #(
   parameter int DIV_W   = 25,
   parameter int DIVISOR = 300
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   // floor(x * RECIP / 2^SHIFT) equals floor(x / DIVISOR) for every x below 2^DIV_W
   localparam int     LOG_D   = $clog2(DIVISOR);
   localparam int     SHIFT   = DIV_W + LOG_D;
   localparam int     RECIP_W = DIV_W + 1;
   localparam int     PROD_W  = DIV_W + RECIP_W;
   localparam longint RECIP   =
      ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

   logic [DIV_W-1:0]  op_ff, op_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [PROD_W-1:0] prod;

   // Latch the dividend, then one multiply and shift
   always_comb begin
      prod    = PROD_W'(op_ff) * PROD_W'(RECIP_V);
      op_in   = op_ff;
      quo_in  = quo_ff;
      busy_in = 1'b0;
      done_in = 1'b0;
      if (start) begin
         op_in   = dividend;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = DIV_W'(prod >> SHIFT);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // A result only follows the multiply cycle
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a preceding multiply");

   // The sequencer never restarts a division in flight
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   // Done is a single-cycle pulse
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

endmodule

// ===== hw/rtl/wind_window_average_core.sv =====
// Wind window average core: a ring of WINDOW speed/heading samples with a
// Mitsuta circular mean. A sample request (tuser 0) advances the ring
// pointer, then the speed and the vane heading are written there. A compute
// request (tuser 1) reads every entry, one per cycle, over the single RAM read
// port, waits for the last read to land, makes two passes of the shared
// reciprocal-multiply divider, and loads the output register; req_tready is
// low throughout. After reset the ring is cleared one entry per cycle with
// req_tready low. A finished result waits in the output register while
// samples are taken; a second compute holds in its final state until that
// result has been taken.
module wind_window_average_core
   import wwa_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] speed, [17:8] vane_adc, rest zero
   input  logic                  req_tuser,   // [0] kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [15:0] speed_mean, [24:16] direction_mean
);

   localparam int PTR_W  = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SSUM_W = SPEED_W + CNT_W;
   localparam int ASUM_W = RUN_W + CNT_W;
   localparam int DIV_W  = SSUM_W + 8;
   localparam int MEM_W  = SPEED_W + DIR_W;

   state_type state_ff, state_in;

   logic [PTR_W-1:0]  cnt_ff, cnt_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [PTR_W-1:0]  ptr_next;
   logic              cnt_last;
   logic              req_accept;
   logic              out_free;

   logic              ram_we;
   logic [PTR_W-1:0]  ram_waddr;
   logic [MEM_W-1:0]  ram_wdata;
   logic [MEM_W-1:0]  ram_rdata;
   logic              issue;
   logic              clr_sums;

   logic              rd_valid_ff, rd_first_ff;

   logic [SSUM_W-1:0]        speed_sum_ff, speed_sum_in;
   logic signed [ASUM_W-1:0] angle_sum_ff, angle_sum_in;
   logic signed [RUN_W-1:0]  run_ff, run_in;
   logic signed [RUN_W-1:0]  rd_v;
   logic signed [RUN_W:0]    delta;
   logic [SPEED_W-1:0]       rd_spd;

   logic              div_start;
   logic [DIV_W-1:0]  div_dividend;
   logic              div_done;
   logic [DIV_W-1:0]  div_quo;
   logic              angle_neg;
   logic [ASUM_W-1:0] angle_mag;

   logic [SPD_MEAN_W-1:0] spd_q_ff, spd_q_in;
   logic [RUN_W-2:0]      ang_q_ff, ang_q_in;
   logic signed [RUN_W-1:0] mean, wrap1, wrap2, wrap3;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_load;

   assign req_accept = req_tvalid && req_tready;
   assign cnt_last   = cnt_ff == PTR_W'(WINDOW - 1);
   assign ptr_next   = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:    if (cnt_last) state_in = ST_IDLE;
         ST_IDLE:     if (req_accept && req_tuser == KIND_COMPUTE) state_in = ST_SCAN;
         ST_SCAN:     if (cnt_last) state_in = ST_TAIL;
         ST_TAIL:     state_in = ST_SPD_GO;
         ST_SPD_GO:   state_in = ST_SPD_WAIT;
         ST_SPD_WAIT: if (div_done) state_in = ST_ANG_GO;
         ST_ANG_GO:   state_in = ST_ANG_WAIT;
         ST_ANG_WAIT: if (div_done) state_in = ST_FINISH;
         ST_FINISH:   if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready   = 1'b0;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      ram_we       = 1'b0;
      ram_waddr    = cnt_ff;
      ram_wdata    = '0;
      issue        = 1'b0;
      clr_sums     = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      spd_q_in     = spd_q_ff;
      ang_q_in     = ang_q_ff;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            cnt_in = cnt_last ? '0 : cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               if (req_tuser == KIND_COMPUTE) begin
                  clr_sums = 1'b1;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = ptr_next;
                  ram_wdata = {heading_of(req_tdata[SPEED_W +: VANE_W]),
                               req_tdata[SPEED_W-1:0]};
                  ptr_in    = ptr_next;
               end
            end
         end
         ST_SCAN: begin
            issue  = 1'b1;
            cnt_in = cnt_last ? '0 : cnt_ff + 1'b1;
         end
         ST_SPD_GO: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'({speed_sum_ff, 8'd0});
         end
         ST_SPD_WAIT: if (div_done) spd_q_in = div_quo[SPD_MEAN_W-1:0];
         ST_ANG_GO: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(angle_mag);
         end
         ST_ANG_WAIT: if (div_done) ang_q_in = div_quo[RUN_W-2:0];
         ST_FINISH:   rsp_load = out_free;
         default: ;
      endcase
   end

   // Unwrap and accumulate the entry whose read was issued in the previous cycle
   always_comb begin
      rd_spd = ram_rdata[SPEED_W-1:0];
      rd_v   = RUN_W'($signed(ram_rdata[SPEED_W +: DIR_W]));
      delta  = (RUN_W + 1)'(rd_v) - (RUN_W + 1)'(run_ff);
      if (rd_first_ff) run_in = rd_v;
      else if (delta < -DEG_HALF) run_in = rd_v + DEG_FULL;
      else if (delta > DEG_HALF) run_in = rd_v - DEG_FULL;
      else run_in = rd_v;
      speed_sum_in = speed_sum_ff;
      angle_sum_in = angle_sum_ff;
      if (clr_sums) begin
         speed_sum_in = '0;
         angle_sum_in = '0;
      end else if (rd_valid_ff) begin
         speed_sum_in = speed_sum_ff + SSUM_W'(rd_spd);
         angle_sum_in = angle_sum_ff + ASUM_W'(run_in);
      end
   end

   // Truncating signed divide works on the magnitude
   assign angle_neg = angle_sum_ff[ASUM_W-1];
   assign angle_mag = angle_neg ? -angle_sum_ff : angle_sum_ff;

   // Restore the sign, then wrap into 0..359
   always_comb begin
      mean  = angle_neg ? -$signed({1'b0, ang_q_ff}) : $signed({1'b0, ang_q_ff});
      wrap1 = (mean < 0) ? mean + DEG_FULL : mean;
      wrap2 = (wrap1 < 0) ? wrap1 + DEG_FULL : wrap1;
      wrap3 = (wrap2 >= DEG_FULL) ? wrap2 - DEG_FULL : wrap2;
      rsp_data_in = {7'd0, wrap3[DIR_MEAN_W-1:0], spd_q_ff};
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rd_first_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ptr_ff       <= ptr_in;
         rd_valid_ff  <= issue;
         rd_first_ff  <= issue && cnt_ff == '0;
         rsp_valid_ff <= rsp_valid_in;
      end
      speed_sum_ff <= speed_sum_in;
      angle_sum_ff <= angle_sum_in;
      if (rd_valid_ff) run_ff <= run_in;
      spd_q_ff <= spd_q_in;
      ang_q_ff <= ang_q_in;
      if (rsp_load) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   wwa_ram #(
      .WIDTH(MEM_W),
      .DEPTH(WINDOW)
   ) u_ring (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(cnt_ff),
      .rdata(ram_rdata)
   );

   wwa_div #(
      .DIV_W  (DIV_W),
      .DIVISOR(WINDOW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .done    (div_done),
      .quotient(div_quo)
   );

   // A new result appears only out of the final state
   a_load_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result loaded outside finish");

   // The last entry of the walk is still in flight in the tail state after the scan
   a_tail_has_data: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TAIL |-> rd_valid_ff && $past(cnt_last))
      else $error("scan tail without read data");

   // Direction is always wrapped into range
   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[SPD_MEAN_W +: DIR_MEAN_W] < 9'd360)
      else $error("direction mean out of range");

   // The mean of 8-bit speeds cannot exceed 255.0
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[SPD_MEAN_W-1:0] <= 16'hFF00)
      else $error("speed mean out of range");

endmodule
